>>> hdl/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// Used by dq_cell, dq_gather and double_ended_queue; depends on nothing.
package dq_pkg;

  localparam int WORD_W      = 32;
  localparam int COUNT_OUT_W = 7;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_INS_LEFT  = 3'd0,
    OP_INS_RIGHT = 3'd1,
    OP_REM_LEFT  = 3'd2,
    OP_REM_RIGHT = 3'd3,
    OP_CLEAR     = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic ins_left;   // everything moves one cell right, new word enters cell 0
    logic rem_left;   // everything moves one cell left
    logic load_tail;  // the cell just past the last word takes the new word
  } cell_ctrl_t;

endpackage

>>> hdl/dq_cell.sv
// One storage cell of the queue chain: holds one word and trades it with
// its neighbors. Depends on dq_pkg.
module dq_cell
  import dq_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CW    = 7
) (
  input  logic          clk,
  input  cell_ctrl_t    ctrl,
  input  logic [CW-1:0] count,
  input  word_t         left_word,
  input  word_t         right_word,
  input  word_t         value_in,
  output word_t         word,
  output word_t         tap
);

  always_ff @(posedge clk) begin
    priority if (ctrl.ins_left) begin
      word <= left_word;
    end else if (ctrl.rem_left) begin
      word <= right_word;
    end else if (ctrl.load_tail && (count == CW'(INDEX))) begin
      word <= value_in;
    end
  end

  // Only the cell holding the rightmost word drives its tap.
  assign tap = (count == CW'(INDEX + 1)) ? word : '0;

endmodule

>>> hdl/dq_gather.sv
// Two-level OR tree that collects the rightmost word from the cell taps,
// with a register after the first level. Depends on dq_pkg.
module dq_gather
  import dq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic  clk,
  input  logic  capture,
  input  word_t taps [DEPTH],
  output word_t word
);

  localparam int GROUP  = 8;
  localparam int NGROUP = (DEPTH + GROUP - 1) / GROUP;

  word_t grp      [NGROUP];
  word_t grp_next [NGROUP];

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < DEPTH) begin
          grp_next[g] = grp_next[g] | taps[g * GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      grp <= grp_next;
    end
  end

  always_comb begin
    word = '0;
    for (int g = 0; g < NGROUP; g++) begin
      word = word | grp[g];
    end
  end

endmodule

>>> hdl/double_ended_queue.sv
// Top level of the double-ended queue: a chain of word cells, a count
// register, the tail gather tree and the result register. Depends on dq_pkg.
//
//   channel | direction | handshake            | beat
//   --------+-----------+----------------------+--------------------------------
//   in      | to block  | in_valid / in_ready   | opcode, value_in
//   out     | from block| out_valid / out_ready | value_out, value_valid,
//           |           |                       | count_after, is_empty, status
//
// Inserts, remove-left, clear and failed removes write the result register
// directly. A successful remove-right passes through S_GATHER: the rightmost word
// is picked out of the chain through the registered two-level OR tree.
// The result register frees the input side as soon as the last result is taken.
// Reset empties the queue at once; cell contents are not cleared.
// A stall on the output holds in_ready low until the result is taken.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OP_W-1:0]        opcode,
  input  logic signed [WORD_W-1:0] value_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [WORD_W-1:0] value_out,
  output logic                   value_valid,
  output logic [COUNT_OUT_W-1:0] count_after,
  output logic                   is_empty,
  output logic [STATUS_W-1:0]    status
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_GATHER = 2'b10
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic          accept;
  logic          full, empty;
  cell_ctrl_t    ctrl, cell_ctrl;
  logic          capture;
  logic          load_now;
  word_t         res_word;
  logic          res_valid;
  status_t       res_status;

  word_t words [DEPTH];
  word_t taps  [DEPTH];
  word_t tail_word;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign in_ready = !rst && (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    count_next = count;
    ctrl       = '0;
    capture    = 1'b0;
    load_now   = 1'b1;
    res_word   = '0;
    res_valid  = 1'b0;
    res_status = ST_OK;
    unique case (op_t'(opcode))
      OP_INS_LEFT: begin
        if (full) begin
          res_status = ST_OVERFLOW;
        end else begin
          ctrl.ins_left = 1'b1;
          count_next    = count + 1'b1;
        end
      end
      OP_INS_RIGHT: begin
        if (full) begin
          res_status = ST_OVERFLOW;
        end else begin
          ctrl.load_tail = 1'b1;
          count_next     = count + 1'b1;
        end
      end
      OP_REM_LEFT: begin
        if (empty) begin
          res_status = ST_UNDERFLOW;
        end else begin
          ctrl.rem_left = 1'b1;
          res_word      = words[0];
          res_valid     = 1'b1;
          count_next    = count - 1'b1;
        end
      end
      OP_REM_RIGHT: begin
        if (empty) begin
          res_status = ST_UNDERFLOW;
        end else begin
          // The word stays in its cell; the count simply stops covering it.
          capture    = 1'b1;
          load_now   = 1'b0;
          count_next = count - 1'b1;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign cell_ctrl = accept ? ctrl : '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = value_in;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    dq_cell #(
      .INDEX(i),
      .CW   (CW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .count     (count),
      .left_word (left_w),
      .right_word(right_w),
      .value_in  (value_in),
      .word      (words[i]),
      .tap       (taps[i])
    );
  end

  dq_gather #(
    .DEPTH(DEPTH)
  ) u_gather (
    .clk    (clk),
    .capture(accept && capture),
    .taps   (taps),
    .word   (tail_word)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept && capture) state_next = S_GATHER;
      S_GATHER: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= count_next;
      end
      if ((accept && load_now) || (state == S_GATHER)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; the count has already been updated when the gather ends.
  always_ff @(posedge clk) begin
    if (state == S_GATHER) begin
      value_out   <= tail_word;
      value_valid <= 1'b1;
      count_after <= COUNT_OUT_W'(count);
      is_empty    <= (count == '0);
      status      <= ST_OK;
    end else if (accept && load_now) begin
      value_out   <= res_word;
      value_valid <= res_valid;
      count_after <= COUNT_OUT_W'(count_next);
      is_empty    <= (count_next == '0);
      status      <= res_status;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count exceeds depth");

  a_gather_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_GATHER) |-> !out_valid)
    else $error("result register busy during tail gather");

  a_rem_right_gathers: assert property (@(posedge clk) disable iff (rst)
    (accept && (opcode == OP_REM_RIGHT) && (count != '0)) |=> (state == S_GATHER))
    else $error("remove-right did not start a gather");

  a_gather_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_GATHER) |=> (out_valid && value_valid && (state == S_IDLE)))
    else $error("gather did not deliver a removed word");

endmodule
